/* rtl/core/izhikevich_neuron_update_unit_assert.svh */
// Assertion macros for the Izhikevich neuron update unit.
// Used by the top level only; needs no package.
`ifndef IZHIKEVICH_NEURON_UPDATE_UNIT_ASSERT_SVH
`define IZHIKEVICH_NEURON_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IZH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("izh assertion failed");

// Next-cycle implication, checked outside reset.
`define IZH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("izh assertion failed");

`endif

/* rtl/core/izh_pkg.sv */
// Shared types, micro-program and constants of the Izhikevich neuron update unit.
// No dependencies.
`default_nettype none

package izh_pkg;

  typedef struct packed {
    logic               action;
    logic [9:0]         neuron_index;
    logic signed [31:0] drive_current;
    logic signed [31:0] ampa_level;
    logic signed [31:0] nmda_level;
    logic signed [31:0] gabaa_level;
    logic signed [31:0] gabab_level;
    logic signed [31:0] mult_factor;
    logic signed [31:0] param_a;
    logic signed [31:0] param_b;
    logic signed [31:0] param_c;
    logic signed [31:0] param_d;
  } izh_in_t;

  typedef struct packed {
    logic               spiked;
    logic signed [31:0] voltage_out;
    logic signed [31:0] recovery_out;
  } izh_out_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIVI, OP_DIVF
  } izh_op_e;

  typedef enum logic [4:0] {
    SRC_V, SRC_R, SRC_ACC, SRC_X, SRC_Y, SRC_DV, SRC_THR, SRC_ZERO,
    SRC_ONE, SRC_K5, SRC_K60, SRC_K70, SRC_K80, SRC_K90, SRC_K140,
    SRC_K004, SRC_K01, SRC_AMPA, SRC_NMDA, SRC_GABAA, SRC_GABAB,
    SRC_MULT, SRC_BASE, SRC_PA, SRC_PB, SRC_PC, SRC_PD
  } izh_src_e;

  typedef enum logic [2:0] {
    DST_V, DST_R, DST_ACC, DST_X, DST_Y, DST_DV
  } izh_dst_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IDX, ST_RD, ST_LD, ST_CHECK, ST_ISSUE, ST_WAIT, ST_BRANCH, ST_WRITE
  } izh_state_e;

  typedef struct packed {
    izh_op_e  op;
    izh_src_e sa;
    izh_src_e sb;
    izh_dst_e dst;
  } izh_uop_t;

  typedef struct packed {
    logic     load_item;
    logic     idx_step;
    logic     mem_re;
    logic     load_state;
    logic     start;
    izh_uop_t uop;
    logic     spike_clr;
    logic     spike_latch;
    logic     mem_we;
    logic     out_load;
  } izh_cmd_t;

  typedef struct packed {
    logic done;
    logic idx_big;
    logic v_lt_thr;
    logic v_gt_thr;
  } izh_status_t;

  localparam int unsigned PcW = 6;

  localparam logic [PcW-1:0] PC_INIT     = 6'd0;
  localparam logic [PcW-1:0] PC_INIT_END = 6'd1;
  localparam logic [PcW-1:0] PC_SUB      = 6'd2;
  localparam logic [PcW-1:0] PC_BRANCH   = 6'd29;
  localparam logic [PcW-1:0] PC_OVER     = 6'd30;
  localparam logic [PcW-1:0] PC_OVER_END = 6'd33;
  localparam logic [PcW-1:0] PC_FLAT     = 6'd34;
  localparam logic [PcW-1:0] PC_REC      = 6'd35;
  localparam logic [PcW-1:0] PC_SUB_END  = 6'd39;
  localparam logic [PcW-1:0] PC_SPK      = 6'd40;
  localparam logic [PcW-1:0] PC_SPK_END  = 6'd41;

  function automatic izh_uop_t uop(input izh_op_e o, input izh_dst_e d,
                                   input izh_src_e a, input izh_src_e b);
    izh_uop_t u;
    u.op  = o;
    u.sa  = a;
    u.sb  = b;
    u.dst = d;
    return u;
  endfunction

  // Micro-program: init, one Euler substep, and the spike reset.
  function automatic izh_uop_t izh_rom(input logic [PcW-1:0] pc);
    izh_uop_t u;
    unique case (pc)
      6'd0:    u = uop(OP_ADD,  DST_V,   SRC_PC,    SRC_ZERO);
      6'd1:    u = uop(OP_MUL,  DST_R,   SRC_PB,    SRC_PC);
      6'd2:    u = uop(OP_MUL,  DST_X,   SRC_AMPA,  SRC_V);
      6'd3:    u = uop(OP_SUB,  DST_ACC, SRC_ZERO,  SRC_X);
      6'd4:    u = uop(OP_ADD,  DST_X,   SRC_V,     SRC_K80);
      6'd5:    u = uop(OP_DIVI, DST_X,   SRC_X,     SRC_K60);
      6'd6:    u = uop(OP_MUL,  DST_Y,   SRC_X,     SRC_X);
      6'd7:    u = uop(OP_ADD,  DST_X,   SRC_Y,     SRC_ONE);
      6'd8:    u = uop(OP_DIVF, DST_Y,   SRC_Y,     SRC_X);
      6'd9:    u = uop(OP_MUL,  DST_X,   SRC_NMDA,  SRC_Y);
      6'd10:   u = uop(OP_MUL,  DST_X,   SRC_X,     SRC_V);
      6'd11:   u = uop(OP_SUB,  DST_ACC, SRC_ACC,   SRC_X);
      6'd12:   u = uop(OP_ADD,  DST_X,   SRC_V,     SRC_K70);
      6'd13:   u = uop(OP_MUL,  DST_X,   SRC_GABAA, SRC_X);
      6'd14:   u = uop(OP_SUB,  DST_ACC, SRC_ACC,   SRC_X);
      6'd15:   u = uop(OP_ADD,  DST_X,   SRC_V,     SRC_K90);
      6'd16:   u = uop(OP_MUL,  DST_X,   SRC_GABAB, SRC_X);
      6'd17:   u = uop(OP_SUB,  DST_ACC, SRC_ACC,   SRC_X);
      6'd18:   u = uop(OP_ADD,  DST_X,   SRC_ONE,   SRC_MULT);
      6'd19:   u = uop(OP_MUL,  DST_ACC, SRC_ACC,   SRC_X);
      6'd20:   u = uop(OP_ADD,  DST_ACC, SRC_ACC,   SRC_BASE);
      6'd21:   u = uop(OP_MUL,  DST_X,   SRC_K004,  SRC_V);
      6'd22:   u = uop(OP_MUL,  DST_X,   SRC_X,     SRC_V);
      6'd23:   u = uop(OP_MUL,  DST_Y,   SRC_V,     SRC_K5);
      6'd24:   u = uop(OP_ADD,  DST_DV,  SRC_X,     SRC_Y);
      6'd25:   u = uop(OP_ADD,  DST_DV,  SRC_DV,    SRC_K140);
      6'd26:   u = uop(OP_SUB,  DST_DV,  SRC_DV,    SRC_R);
      6'd27:   u = uop(OP_ADD,  DST_DV,  SRC_DV,    SRC_ACC);
      6'd28:   u = uop(OP_MUL,  DST_X,   SRC_DV,    SRC_K01);
      6'd29:   u = uop(OP_ADD,  DST_V,   SRC_V,     SRC_X);
      6'd30:   u = uop(OP_SUB,  DST_X,   SRC_THR,   SRC_V);
      6'd31:   u = uop(OP_ADD,  DST_X,   SRC_X,     SRC_DV);
      6'd32:   u = uop(OP_DIVF, DST_Y,   SRC_DV,    SRC_X);
      6'd33:   u = uop(OP_MUL,  DST_Y,   SRC_Y,     SRC_K01);
      6'd34:   u = uop(OP_ADD,  DST_Y,   SRC_K01,   SRC_ZERO);
      6'd35:   u = uop(OP_MUL,  DST_X,   SRC_PB,    SRC_V);
      6'd36:   u = uop(OP_SUB,  DST_X,   SRC_X,     SRC_R);
      6'd37:   u = uop(OP_MUL,  DST_X,   SRC_PA,    SRC_X);
      6'd38:   u = uop(OP_MUL,  DST_X,   SRC_X,     SRC_Y);
      6'd39:   u = uop(OP_ADD,  DST_R,   SRC_R,     SRC_X);
      6'd40:   u = uop(OP_ADD,  DST_V,   SRC_PC,    SRC_ZERO);
      6'd41:   u = uop(OP_ADD,  DST_R,   SRC_R,     SRC_PD);
      default: u = uop(OP_ADD,  DST_X,   SRC_ZERO,  SRC_ZERO);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/izh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module izh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/izh_datapath.sv */
// Datapath: operand registers, saturating adder, multiplier, radix-2 divider,
// and the neuron state RAM. Depends on izh_pkg and izh_ram.
`default_nettype none

module izh_datapath import izh_pkg::*; #(
  parameter int unsigned NEURON_COUNT  = 1024,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire izh_in_t     item_i,
  input  wire logic [30:0] thr_i,
  input  wire izh_cmd_t    cmd_i,
  output izh_status_t      status_o,
  output izh_out_t         out_o
);

  localparam int unsigned AW = NEURON_COUNT > 1 ? $clog2(NEURON_COUNT) : 1;
  localparam int unsigned DW = 32 + FRACTION_BITS;
  localparam int unsigned DCW = $clog2(DW + 1);

  localparam longint OneL = longint'(1) << FRACTION_BITS;
  localparam logic signed [33:0] KOne  = 34'(OneL);
  localparam logic signed [33:0] K5    = 34'(5 * OneL);
  localparam logic signed [33:0] K60   = 34'(60);
  localparam logic signed [33:0] K70   = 34'(70 * OneL);
  localparam logic signed [33:0] K80   = 34'(80 * OneL);
  localparam logic signed [33:0] K90   = 34'(90 * OneL);
  localparam logic signed [33:0] K140  = 34'(140 * OneL);
  localparam logic signed [33:0] K004  = 34'((4 * OneL + 50) / 100);
  localparam logic signed [33:0] K01   = 34'((OneL + 5) / 10);
  localparam logic [16:0]        NcL   = 17'(NEURON_COUNT);
  localparam logic [DW-1:0]      QLim  = DW'(64'd2147483648);
  localparam logic [DW-1:0]      QMax  = DW'(64'd2147483647);
  localparam logic signed [31:0] SMax  = 32'sh7fffffff;
  localparam logic signed [31:0] SMin  = 32'sh80000000;
  // ceil(2^34 / 15): (m / 4) * Div15M >> 34 is m / 60 for every 32-bit magnitude.
  localparam logic [30:0]        Div15M = 31'd1145324613;

  function automatic logic signed [33:0] ext(input logic signed [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
    if (x > 35'sd2147483647) begin
      return SMax;
    end else if (x < -35'sd2147483648) begin
      return SMin;
    end
    return x[31:0];
  endfunction

  izh_in_t            item_q;
  logic [9:0]         idx_q;
  logic signed [31:0] v_q, r_q, acc_q, x_q, y_q, dv_q;
  logic               spike_q;
  logic signed [63:0] p_q;
  logic               mul_pend_q;
  logic               div_busy_q;
  logic [DCW-1:0]     div_cnt_q;
  logic [31:0]        rem_q, dmag_q;
  logic [DW-1:0]      quo_q;
  logic               div_neg_q, d_zero_q, n_pos_q, n_neg_q;
  izh_out_t           out_q;
  logic [63:0]        rdata;
  logic [AW-1:0]      addr;

  logic signed [33:0] opa, opb;
  logic signed [31:0] alu_res, mul_res, div_res, divi_res, wr_val;
  logic signed [63:0] mul_sh;
  logic               done;
  logic [32:0]        trial;
  logic [31:0]        n_mag, d_mag;
  logic [60:0]        recip_p;
  logic [26:0]        q60;

  function automatic logic signed [33:0] pick(input izh_src_e s);
    logic signed [33:0] o;
    case (s)
      SRC_V:     o = ext(v_q);
      SRC_R:     o = ext(r_q);
      SRC_ACC:   o = ext(acc_q);
      SRC_X:     o = ext(x_q);
      SRC_Y:     o = ext(y_q);
      SRC_DV:    o = ext(dv_q);
      SRC_THR:   o = {3'b000, thr_i};
      SRC_ONE:   o = KOne;
      SRC_K5:    o = K5;
      SRC_K60:   o = K60;
      SRC_K70:   o = K70;
      SRC_K80:   o = K80;
      SRC_K90:   o = K90;
      SRC_K140:  o = K140;
      SRC_K004:  o = K004;
      SRC_K01:   o = K01;
      SRC_AMPA:  o = ext(item_q.ampa_level);
      SRC_NMDA:  o = ext(item_q.nmda_level);
      SRC_GABAA: o = ext(item_q.gabaa_level);
      SRC_GABAB: o = ext(item_q.gabab_level);
      SRC_MULT:  o = ext(item_q.mult_factor);
      SRC_BASE:  o = ext(item_q.drive_current);
      SRC_PA:    o = ext(item_q.param_a);
      SRC_PB:    o = ext(item_q.param_b);
      SRC_PC:    o = ext(item_q.param_c);
      SRC_PD:    o = ext(item_q.param_d);
      default:   o = '0;
    endcase
    return o;
  endfunction

  always_comb begin
    opa = pick(cmd_i.uop.sa);
    opb = pick(cmd_i.uop.sb);
    if (cmd_i.uop.op == OP_SUB) begin
      alu_res = sat35({opa[33], opa} - {opb[33], opb});
    end else begin
      alu_res = sat35({opa[33], opa} + {opb[33], opb});
    end
  end

  // The arithmetic shift of the full product rounds toward minus infinity.
  always_comb begin
    mul_sh = p_q >>> FRACTION_BITS;
    if (mul_sh > 64'sd2147483647) begin
      mul_res = SMax;
    end else if (mul_sh < -64'sd2147483648) begin
      mul_res = SMin;
    end else begin
      mul_res = mul_sh[31:0];
    end
  end

  always_comb begin
    n_mag = opa[31] ? 32'(-opa[31:0]) : opa[31:0];
    d_mag = opb[31] ? 32'(-opb[31:0]) : opb[31:0];
    trial = {rem_q, quo_q[DW-1]};
    recip_p = n_mag[31:2] * Div15M;
    q60 = p_q[60:34];
    divi_res = div_neg_q ? 32'(-{5'b00000, q60}) : {5'b00000, q60};
    if (d_zero_q) begin
      div_res = n_pos_q ? SMax : (n_neg_q ? SMin : '0);
    end else if (div_neg_q) begin
      div_res = (quo_q > QLim) ? SMin : 32'(-quo_q[31:0]);
    end else begin
      div_res = (quo_q > QMax) ? SMax : quo_q[31:0];
    end
  end

  always_comb begin
    done = (cmd_i.start && (cmd_i.uop.op == OP_ADD || cmd_i.uop.op == OP_SUB)) ||
           mul_pend_q || (div_busy_q && div_cnt_q == '0);
    case (cmd_i.uop.op)
      OP_ADD, OP_SUB: wr_val = alu_res;
      OP_MUL:         wr_val = mul_res;
      OP_DIVI:        wr_val = divi_res;
      default:        wr_val = div_res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_pend_q <= 1'b0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      mul_pend_q <= cmd_i.start && (cmd_i.uop.op == OP_MUL || cmd_i.uop.op == OP_DIVI);
      if (cmd_i.start && cmd_i.uop.op == OP_DIVF) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= DCW'(DW);
      end else if (div_busy_q) begin
        if (div_cnt_q == '0) begin
          div_busy_q <= 1'b0;
        end else begin
          div_cnt_q <= div_cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
      idx_q  <= item_i.neuron_index;
    end else if (cmd_i.idx_step) begin
      idx_q <= idx_q - NcL[9:0];
    end
    if (cmd_i.start) begin
      if (cmd_i.uop.op == OP_DIVI) begin
        p_q <= $signed({3'b000, recip_p});
      end else begin
        p_q <= $signed(opa[31:0]) * $signed(opb[31:0]);
      end
    end
    if (cmd_i.start && (cmd_i.uop.op == OP_DIVI || cmd_i.uop.op == OP_DIVF)) begin
      div_neg_q <= opa[31] ^ opb[31];
    end
    if (cmd_i.start && cmd_i.uop.op == OP_DIVF) begin
      rem_q     <= '0;
      dmag_q    <= d_mag;
      d_zero_q  <= opb[31:0] == '0;
      n_pos_q   <= !opa[31] && opa[31:0] != '0;
      n_neg_q   <= opa[31];
      quo_q     <= DW'(n_mag) << FRACTION_BITS;
    end else if (div_busy_q && div_cnt_q != '0) begin
      if (trial >= {1'b0, dmag_q}) begin
        rem_q <= 32'(trial - {1'b0, dmag_q});
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.load_state) begin
      v_q <= rdata[63:32];
      r_q <= rdata[31:0];
    end else if (done) begin
      case (cmd_i.uop.dst)
        DST_V:   v_q   <= wr_val;
        DST_R:   r_q   <= wr_val;
        DST_ACC: acc_q <= wr_val;
        DST_X:   x_q   <= wr_val;
        DST_Y:   y_q   <= wr_val;
        default: dv_q  <= wr_val;
      endcase
    end
    if (cmd_i.spike_clr) begin
      spike_q <= 1'b0;
    end else if (cmd_i.spike_latch) begin
      spike_q <= !status_o.v_lt_thr;
    end
    if (cmd_i.out_load) begin
      out_q.spiked       <= spike_q;
      out_q.voltage_out  <= v_q;
      out_q.recovery_out <= r_q;
    end
  end

  generate
    if (AW >= 10) begin : g_wide_addr
      assign addr = AW'(idx_q);
    end else begin : g_narrow_addr
      assign addr = idx_q[AW-1:0];
    end
  endgenerate

  izh_ram #(
    .WIDTH(64),
    .DEPTH(NEURON_COUNT)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_we),
    .waddr_i(addr),
    .wdata_i({v_q, r_q}),
    .re_i   (cmd_i.mem_re),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  assign status_o.done     = done;
  assign status_o.idx_big  = {7'b0, idx_q} >= NcL;
  assign status_o.v_lt_thr = v_q < $signed({1'b0, thr_i});
  assign status_o.v_gt_thr = v_q > $signed({1'b0, thr_i});
  assign out_o             = out_q;

endmodule

`default_nettype wire

/* rtl/core/izh_ctrl.sv */
// Controller: sequences the micro-program over the datapath and runs the handshakes.
// Depends on izh_pkg.
`default_nettype none

module izh_ctrl import izh_pkg::*; #(
  parameter int unsigned EULER_SUBSTEPS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_action_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire izh_status_t status_i,
  output izh_cmd_t         cmd_o
);

  localparam int unsigned CW = $clog2(EULER_SUBSTEPS + 1);

  izh_state_e     state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           action_q;
  logic           out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_IDX;
      end
      ST_IDX: begin
        if (!status_i.idx_big) begin
          if (action_q) begin
            pc_d    = PC_INIT;
            state_d = ST_ISSUE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: state_d = ST_LD;
      ST_LD: begin
        cnt_d   = '0;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (cnt_q < CW'(EULER_SUBSTEPS) && status_i.v_lt_thr) begin
          pc_d    = PC_SUB;
          state_d = ST_ISSUE;
        end else if (!status_i.v_lt_thr) begin
          pc_d    = PC_SPK;
          state_d = ST_ISSUE;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_ISSUE, ST_WAIT: begin
        if (status_i.done) begin
          if (pc_q == PC_INIT_END || pc_q == PC_SPK_END) begin
            state_d = ST_WRITE;
          end else if (pc_q == PC_BRANCH) begin
            state_d = ST_BRANCH;
          end else if (pc_q == PC_OVER_END) begin
            pc_d    = PC_REC;
            state_d = ST_ISSUE;
          end else if (pc_q == PC_SUB_END) begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_CHECK;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end else begin
          state_d = ST_WAIT;
        end
      end
      // The new voltage is in its register now; pick the recovery step length.
      ST_BRANCH: begin
        pc_d    = status_i.v_gt_thr ? PC_OVER : PC_FLAT;
        state_d = ST_ISSUE;
      end
      ST_WRITE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.uop         = izh_rom(pc_q);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_item = in_valid_i;
        cmd_o.spike_clr = in_valid_i;
      end
      ST_IDX:   cmd_o.idx_step   = status_i.idx_big;
      ST_RD:    cmd_o.mem_re     = 1'b1;
      ST_LD:    cmd_o.load_state = 1'b1;
      ST_CHECK: begin
        cmd_o.spike_latch = !(cnt_q < CW'(EULER_SUBSTEPS) && status_i.v_lt_thr);
      end
      ST_ISSUE: cmd_o.start = 1'b1;
      ST_WAIT, ST_BRANCH: ;
      ST_WRITE: begin
        cmd_o.mem_we   = !out_valid_q || !out_stall_i;
        cmd_o.out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      action_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_IDLE && in_valid_i) action_q <= in_action_i;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/izhikevich_neuron_update_unit.sv */
// Top level of the Izhikevich neuron update unit: threshold register,
// controller and datapath. Depends on izh_pkg, izh_ctrl, izh_datapath.
//
// Channel  Dir  Handshake       Payload
// in       in   valid / stall   izh_in_t (tick or init item)
// out      out  valid / stall   izh_out_t (spike flag, voltage, recovery)
// cfg      in   valid / ready   spike threshold, 31 bits
//
// A tick runs longer than an init item, and longer still when it spikes; each
// Euler substep adds to it, and a substep that overshoots the threshold adds
// more; the one-bit-per-cycle divider and the multiplier set the substep length.
// Reset clears the controller and sets the threshold to 30.0; the neuron RAM
// is not cleared. A stalled result holds in the output register while the
// next item is taken in.
`default_nettype none

module izhikevich_neuron_update_unit import izh_pkg::*; #(
  parameter int unsigned NEURON_COUNT   = 1024,
  parameter int unsigned EULER_SUBSTEPS = 10,
  parameter int unsigned FRACTION_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire izh_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output izh_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [30:0] cfg_data_i
);

`include "izhikevich_neuron_update_unit_assert.svh"

  logic [30:0] thr_q;
  izh_cmd_t    cmd;
  izh_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 31'd1966080;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  izh_ctrl #(
    .EULER_SUBSTEPS(EULER_SUBSTEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_action_i(in_data_i.action),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  izh_datapath #(
    .NEURON_COUNT (NEURON_COUNT),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_data_i),
    .thr_i   (thr_q),
    .cmd_i   (cmd),
    .status_o(status),
    .out_o   (out_data_o)
  );

  // Once a transfer is taken in, the unit is busy on the following cycle.
  `IZH_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // A loaded result shows up as valid on the output.
  `IZH_ASSERT_NEXT(a_result_valid, clk_i, rst_ni, cmd.out_load, out_valid_o)
  // No datapath operation starts in the cycle an item is taken in.
  `IZH_ASSERT_IMPL(a_no_start_idle, clk_i, rst_ni, in_valid_i && !in_stall_o, !cmd.start)
  // State write-back and result load always happen together.
  `IZH_ASSERT_IMPL(a_write_with_out, clk_i, rst_ni, cmd.mem_we, cmd.out_load)

endmodule

`default_nettype wire

/* tb/izhikevich_neuron_update_unit_tb.sv */
// Self-checking testbench for the Izhikevich neuron update unit.
// Depends on izh_pkg and izhikevich_neuron_update_unit; predicts each result itself.
`default_nettype none

module izhikevich_neuron_update_unit_tb;
  import izh_pkg::*;

  localparam int NEURONS = 1024;
  localparam int SUBSTEPS = 10;
  localparam int FBITS = 16;
  localparam longint FX_ONE = 64'sd1 << FBITS;
  localparam longint K004 = (4 * FX_ONE + 50) / 100;
  localparam longint K01 = (FX_ONE + 5) / 10;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam logic [30:0] THR_DEFAULT = 31'd1966080;
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_INIT = 1'b1;

  function automatic longint clamp32(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  function automatic longint fx_mul(longint x, longint y);
    longint p;
    p = x * y;
    return clamp32(p >>> FBITS);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    if (d == 0) return (n > 0) ? SMAX : ((n < 0) ? SMIN : 0);
    return clamp32((n * FX_ONE) / d);
  endfunction

  class neuron_scoreboard;
    longint volt [NEURONS];
    longint recov [NEURONS];
    longint thr;
    izh_out_t pending[$];
    int errors;

    function new();
      thr = THR_DEFAULT;
      errors = 0;
    endfunction

    function void note_item(izh_in_t it);
      longint v, r, cur, s, t, sig, dv, tau;
      longint amp, nm, ga, gb, mu, bs, pa, pb, pc, pd;
      int idx;
      izh_out_t res;
      idx = it.neuron_index % NEURONS;
      amp = it.ampa_level; nm = it.nmda_level; ga = it.gabaa_level;
      gb = it.gabab_level; mu = it.mult_factor; bs = it.drive_current;
      pa = it.param_a; pb = it.param_b; pc = it.param_c; pd = it.param_d;
      res.spiked = 1'b0;
      if (it.action == ACT_INIT) begin
        v = pc;
        r = fx_mul(pb, pc);
      end else begin
        v = volt[idx];
        r = recov[idx];
        for (int i = 0; i < SUBSTEPS && v < thr; i++) begin
          cur = clamp32(-fx_mul(amp, v));
          s = clamp32(v + 80 * FX_ONE) / 60;
          t = fx_mul(s, s);
          sig = fx_div(t, clamp32(FX_ONE + t));
          cur = clamp32(cur - fx_mul(fx_mul(nm, sig), v));
          cur = clamp32(cur - fx_mul(ga, clamp32(v + 70 * FX_ONE)));
          cur = clamp32(cur - fx_mul(gb, clamp32(v + 90 * FX_ONE)));
          cur = fx_mul(cur, clamp32(FX_ONE + mu));
          cur = clamp32(cur + bs);
          dv = fx_mul(fx_mul(K004, v), v);
          dv = clamp32(dv + clamp32(5 * v));
          dv = clamp32(dv + 140 * FX_ONE);
          dv = clamp32(dv - r);
          dv = clamp32(dv + cur);
          v = clamp32(v + fx_mul(dv, K01));
          // An overshooting substep shortens the recovery step.
          if (v > thr) tau = fx_mul(fx_div(dv, clamp32(clamp32(thr - v) + dv)), K01);
          else tau = K01;
          r = clamp32(r + fx_mul(fx_mul(pa, clamp32(fx_mul(pb, v) - r)), tau));
        end
        if (v >= thr) begin
          res.spiked = 1'b1;
          v = pc;
          r = clamp32(r + pd);
        end
      end
      volt[idx] = v;
      recov[idx] = r;
      res.voltage_out = v[31:0];
      res.recovery_out = r[31:0];
      pending.push_back(res);
    endfunction

    function void check_result(izh_out_t got);
      izh_out_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.spiked !== exp_r.spiked) begin
        $error("spiked: expected %0d actual %0d", exp_r.spiked, got.spiked);
        errors++;
      end
      if (got.voltage_out !== exp_r.voltage_out) begin
        $error("voltage_out: expected %0d actual %0d", exp_r.voltage_out, got.voltage_out);
        errors++;
      end
      if (got.recovery_out !== exp_r.recovery_out) begin
        $error("recovery_out: expected %0d actual %0d", exp_r.recovery_out,
               got.recovery_out);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  izh_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  izh_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [30:0] cfg_data_i = '0;

  neuron_scoreboard sb = new();
  bit written [NEURONS];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;

  izhikevich_neuron_update_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: stall decided at the falling edge, results checked at the rising edge.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Valid stays up between back-to-back items; it drops only while the sender idles.
  task automatic send_item(izh_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    written[it.neuron_index % NEURONS] = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [30:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.thr = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_fx(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'(int'($urandom_range(40)) - 20) <<< FBITS;
      2: return 32'(int'($urandom_range(65536)) - 32768);
      default: return 32'(int'($urandom_range(200)) - 100) <<< (FBITS - 4);
    endcase
  endfunction

  // Mostly plausible neurons with random content, with some wild values mixed in.
  function automatic izh_in_t rand_item(bit force_init);
    izh_in_t it;
    int m;
    m = ($urandom_range(9) == 0) ? 0 : 1 + $urandom_range(2);
    it.neuron_index = ($urandom_range(3) == 0) ? 10'($urandom()) : 10'($urandom_range(15));
    it.action = (force_init || !written[it.neuron_index] || $urandom_range(7) == 0)
                ? ACT_INIT : ACT_TICK;
    it.drive_current = (m == 0) ? rand_fx(0) : 32'(int'($urandom_range(30)) << FBITS);
    it.ampa_level = rand_fx(m == 0 ? 0 : 2);
    it.nmda_level = rand_fx(m == 0 ? 0 : 2);
    it.gabaa_level = rand_fx(m == 0 ? 0 : 2);
    it.gabab_level = rand_fx(m == 0 ? 0 : 2);
    it.mult_factor = rand_fx(m == 0 ? 0 : 2);
    it.param_a = (m == 0) ? rand_fx(0) : 32'($urandom_range(6554));
    it.param_b = (m == 0) ? rand_fx(0) : 32'($urandom_range(16384));
    it.param_c = (m == 0) ? rand_fx(0) : -32'(int'($urandom_range(50, 70)) << FBITS);
    it.param_d = (m == 0) ? rand_fx(0) : 32'(int'($urandom_range(8)) << FBITS);
    return it;
  endfunction

  task automatic directed();
    izh_in_t it;
    logic [31:0] corner [4];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    for (int k = 0; k < 4; k++) begin
      it = '0;
      it.action = ACT_INIT;
      it.neuron_index = 10'(k);
      it.param_b = corner[k];
      it.param_c = corner[(k + 1) % 4];
      send_item(it);
      it = '{default: corner[k]};
      it.action = ACT_TICK;
      it.neuron_index = 10'(k);
      send_item(it);
    end
    // Neuron sitting exactly at the threshold spikes with no substep.
    it = '0;
    it.action = ACT_INIT;
    it.neuron_index = 10'h3ff;
    it.param_c = 32'(THR_DEFAULT);
    send_item(it);
    it.action = ACT_TICK;
    it.param_d = 32'h7fff_ffff;
    send_item(it);
    // Strong drive overshoots the threshold; rest is a quiet neuron.
    it = rand_item(1'b1);
    it.neuron_index = 10'd5;
    send_item(it);
    it.action = ACT_TICK;
    it.drive_current = 32'sd500 <<< FBITS;
    send_item(it);
    it.drive_current = '0;
    send_item(it);
    it = rand_item(1'b0);
    it.neuron_index = 10'd5;
    it.action = ACT_TICK;
    it.mult_factor = -32'sd1 <<< FBITS;
    send_item(it);
  endtask

  task automatic random_phase(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) send_item(rand_item(1'b0));
    drain();
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed();
    drain();
    write_threshold(31'd0);
    random_phase(150, 7, 58);
    write_threshold(31'h7fff_ffff);
    random_phase(150, 58, 7);
    write_threshold(31'($urandom_range(40) << FBITS));
    hold_off_cycles <= 2000;
    random_phase(550, 0, 0);
    write_threshold(THR_DEFAULT);
    random_phase(400, 7, 58);
    random_phase(330, 0, 0);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS izhikevich_neuron_update_unit");
    end else begin
      $display("FAIL izhikevich_neuron_update_unit");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("FAIL izhikevich_neuron_update_unit");
    $finish;
  end

endmodule

`default_nettype wire
